### src/assert_macros.svh
// Assertion macros shared by the segmenter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### src/sos_pkg.sv
// Package: widths, constants and status type of the scan object segmenter.
`timescale 1ns / 1ps
package sos_pkg;

    localparam int MAX_SAMPLES_DEF = 256;
    localparam int MAX_OBJECTS_DEF = 10;

    localparam int DIST_W     = 16;
    localparam int SUM_W      = 24;
    localparam int LIN_W      = 20;
    localparam int NUM_W      = 4;
    localparam int ANG_W      = 8;
    localparam int SPAN_OUT_W = 9;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 64;

    localparam logic [DIST_W-1:0] THR_RESET = 16'd1248;

    // round(pi/180 * 2^24)
    localparam int                K_W        = 19;
    localparam logic [K_W-1:0]    K_DEG2RAD  = 19'd292818;
    localparam int                FRAC_SHIFT = 24;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

endpackage

### src/scan_object_segmenter_top.sv
// Top level: sweep segmenter, run tracking, best-object select and result register.
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: ir_cm, sonar_cm; tlast
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: found .. lin_size
//  cfg      in   i_cfg_wr_en                  i_cfg_wr_data: near_limit
//
//  A sample that neither closes an object nor is last leaves tready high.
//  A closing sample (object count below MAX_OBJECTS) holds tready low through the
//  divider (24 quotient bits, done), multiplier unit (two passes, round, done) and
//  update. A last sample then enters a state that loads the result register; that
//  state waits, tready low, while the register still holds an unaccepted result.
//  Synchronous active-low reset clears sweep state; threshold returns to 1248 cm.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scan_object_segmenter_top #(
    parameter int MAX_SAMPLES = sos_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_OBJECTS = sos_pkg::MAX_OBJECTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [sos_pkg::DIST_W-1:0]        i_cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] ir_cm, [31:16] sonar_cm
    input  logic [sos_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] found, [4:1] object_number, [12:5] start_angle, [21:13] angular_width,
    // [37:22] avg_distance, [57:38] lin_size, [63:58] zero
    output logic [sos_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import sos_pkg::*;

    localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
    localparam int PAY_W = 1 + NUM_W + ANG_W + SPAN_OUT_W + DIST_W + LIN_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [DIST_W-1:0]   r_thr;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_in_obj, n_in_obj;
    logic [IDX_W-1:0]    r_run_start, n_run_start;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [NUM_W-1:0]    r_obj_cnt, n_obj_cnt;
    logic [NUM_W-1:0]    r_best_num, n_best_num;
    logic [IDX_W-1:0]    r_best_start, n_best_start;
    logic [IDX_W-1:0]    r_best_span, n_best_span;
    logic [DIST_W-1:0]   r_best_dist, n_best_dist;
    logic [LIN_W-1:0]    r_best_lin, n_best_lin;
    logic [IDX_W-1:0]    r_cand_start, n_cand_start;
    logic [IDX_W-1:0]    r_cand_span, n_cand_span;
    logic [DIST_W-1:0]   r_cand_avg, n_cand_avg;
    logic                r_last, n_last;
    logic                r_out_valid, n_out_valid;
    logic [PAY_W-1:0]    r_out_data, n_out_data;

    logic                accept;
    logic [DIST_W-1:0]   in_ir;
    logic [DIST_W-1:0]   in_sonar;
    logic [SUM_W:0]      sum_add;
    logic                div_start;
    logic [IDX_W-1:0]    div_span;
    logic [SUM_W-1:0]    div_quo;
    logic [DIST_W-1:0]   quo_clamped;
    t_unit_status        div_sts;
    logic                lin_start;
    logic [LIN_W-1:0]    lin_val;
    t_unit_status        lin_sts;

    assign in_ir         = s_axis_tdata[DIST_W-1:0];
    assign in_sonar      = s_axis_tdata[2*DIST_W-1:DIST_W];
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign sum_add       = {1'b0, r_sum} + (SUM_W+1)'(in_sonar);
    assign div_span      = r_idx - r_run_start;
    assign quo_clamped   = (|div_quo[SUM_W-1:DIST_W]) ? '1 : div_quo[DIST_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_in_obj     = r_in_obj;
        n_run_start  = r_run_start;
        n_sum        = r_sum;
        n_obj_cnt    = r_obj_cnt;
        n_best_num   = r_best_num;
        n_best_start = r_best_start;
        n_best_span  = r_best_span;
        n_best_dist  = r_best_dist;
        n_best_lin   = r_best_lin;
        n_cand_start = r_cand_start;
        n_cand_span  = r_cand_span;
        n_cand_avg   = r_cand_avg;
        n_last       = r_last;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        div_start    = 1'b0;
        lin_start    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_last  = s_axis_tlast;
                    n_state = s_axis_tlast ? S_OUT : S_IDLE;
                    if (r_idx < IDX_W'(MAX_SAMPLES)) begin
                        n_idx = r_idx + IDX_W'(1);
                        if (in_ir < r_thr) begin
                            if (!r_in_obj) begin
                                n_in_obj    = 1'b1;
                                n_run_start = r_idx;
                                n_sum       = SUM_W'(in_sonar);
                            end else begin
                                n_sum = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                            end
                        end else if (r_in_obj) begin
                            n_in_obj = 1'b0;
                            n_sum    = '0;
                            if (r_obj_cnt < NUM_W'(MAX_OBJECTS)) begin
                                div_start    = 1'b1;
                                n_cand_start = r_run_start;
                                n_cand_span  = div_span;
                                n_state      = S_DIV;
                            end
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_sts.done) begin
                    n_cand_avg = quo_clamped;
                    lin_start  = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                if (lin_sts.done) begin
                    n_obj_cnt = r_obj_cnt + NUM_W'(1);
                    if (r_obj_cnt == '0 || lin_val < r_best_lin) begin
                        n_best_num   = r_obj_cnt + NUM_W'(1);
                        n_best_start = r_cand_start;
                        n_best_span  = r_cand_span;
                        n_best_dist  = r_cand_avg;
                        n_best_lin   = lin_val;
                    end
                    n_state = r_last ? S_OUT : S_IDLE;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = {r_best_lin, r_best_dist, SPAN_OUT_W'(r_best_span),
                                    ANG_W'(r_best_start), r_best_num, (r_obj_cnt != '0)};
                    n_idx        = '0;
                    n_in_obj     = 1'b0;
                    n_run_start  = '0;
                    n_sum        = '0;
                    n_obj_cnt    = '0;
                    n_best_num   = '0;
                    n_best_start = '0;
                    n_best_span  = '0;
                    n_best_dist  = '0;
                    n_best_lin   = '0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_thr        <= THR_RESET;
            r_idx        <= '0;
            r_in_obj     <= 1'b0;
            r_run_start  <= '0;
            r_sum        <= '0;
            r_obj_cnt    <= '0;
            r_best_num   <= '0;
            r_best_start <= '0;
            r_best_span  <= '0;
            r_best_dist  <= '0;
            r_best_lin   <= '0;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            r_idx        <= n_idx;
            r_in_obj     <= n_in_obj;
            r_run_start  <= n_run_start;
            r_sum        <= n_sum;
            r_obj_cnt    <= n_obj_cnt;
            r_best_num   <= n_best_num;
            r_best_start <= n_best_start;
            r_best_span  <= n_best_span;
            r_best_dist  <= n_best_dist;
            r_best_lin   <= n_best_lin;
            r_last       <= n_last;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand_start <= n_cand_start;
        r_cand_span  <= n_cand_span;
        r_cand_avg   <= n_cand_avg;
        r_out_data   <= n_out_data;
    end

    sos_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (IDX_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (div_span),
        .o_quotient (div_quo),
        .o_status   (div_sts)
    );

    sos_lin #(
        .SPAN_W   (IDX_W)
    ) u_lin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (lin_start),
        .i_avg    (quo_clamped),
        .i_span   (r_cand_span),
        .o_linear (lin_val),
        .o_status (lin_sts)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_data);

    `ASSERT_AT(a_busy_not_ready, i_clk, i_rst_n, (div_sts.busy || lin_sts.busy) |-> !s_axis_tready, "busy")
    `ASSERT_AT(a_best_le_cnt, i_clk, i_rst_n, r_best_num <= r_obj_cnt, "best number beyond count")
    `ASSERT_AT(a_cnt_limit, i_clk, i_rst_n, r_obj_cnt <= NUM_W'(MAX_OBJECTS), "count past limit")
    `ASSERT_AT(a_lin_in_mul, i_clk, i_rst_n, lin_sts.done |-> (r_state == S_MUL), "lin done outside update")

endmodule

### src/sos_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sos_div #(
    parameter int DIVIDEND_W = sos_pkg::SUM_W,
    parameter int DIVISOR_W  = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output sos_pkg::t_unit_status o_status
);
    import sos_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign rem_sh = {r_rem, r_quo[DIVIDEND_W-1]};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign diff   = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
        end
    end

    assign o_quotient    = r_quo;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

    `ASSERT_NEVER(a_start_busy, i_clk, i_rst_n, i_start && r_busy, "div started while busy")
    `ASSERT_AT(a_rem_lt_div, i_clk, i_rst_n, r_busy |-> (r_rem < r_div), "remainder too big")
    `ASSERT_AT(a_done_pulse, i_clk, i_rst_n, r_done |=> !r_done, "div done too long")

endmodule

### src/sos_lin.sv
// Linear width unit: one shared multiplier, two passes, then round and saturate.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sos_lin #(
    parameter int SPAN_W = 9
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sos_pkg::DIST_W-1:0]   i_avg,
    input  logic [SPAN_W-1:0]            i_span,
    output logic [sos_pkg::LIN_W-1:0]    o_linear,
    output sos_pkg::t_unit_status        o_status
);
    import sos_pkg::*;

    localparam int A_W    = DIST_W + SPAN_W;
    localparam int B_W    = (SPAN_W > K_W) ? SPAN_W : K_W;
    localparam int FULL_W = DIST_W + SPAN_W + K_W;
    localparam int TOP_B  = FRAC_SHIFT + LIN_W;
    localparam int PROD_W = (FULL_W > TOP_B) ? FULL_W : TOP_B + 1;

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_P1   = 4'b0010,
        L_P2   = 4'b0100,
        L_RND  = 4'b1000
    } t_lstate;

    t_lstate             r_state;
    t_lstate             n_state;
    logic [DIST_W-1:0]   r_avg;
    logic [SPAN_W-1:0]   r_span;
    logic [PROD_W-1:0]   r_prod;
    logic [LIN_W-1:0]    r_lin;
    logic                r_done;

    logic [A_W-1:0]      mul_a;
    logic [B_W-1:0]      mul_b;
    logic [A_W+B_W-1:0]  mul_raw;
    logic [PROD_W:0]     rnd;
    logic                sat;

    assign mul_a   = (r_state == L_P2) ? r_prod[A_W-1:0] : A_W'(r_avg);
    assign mul_b   = (r_state == L_P2) ? B_W'(K_DEG2RAD) : B_W'(r_span);
    assign mul_raw = mul_a * mul_b;
    assign rnd     = {1'b0, r_prod} + ((PROD_W+1)'(1) << (FRAC_SHIFT - 1));
    assign sat     = |rnd[PROD_W:TOP_B];

    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE:  if (i_start) n_state = L_P1;
            L_P1:    n_state = L_P2;
            L_P2:    n_state = L_RND;
            L_RND:   n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == L_RND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_start) begin
            r_avg  <= i_avg;
            r_span <= i_span;
        end
        if (r_state == L_P1 || r_state == L_P2) begin
            r_prod <= PROD_W'(mul_raw);
        end
        if (r_state == L_RND) begin
            r_lin <= sat ? '1 : rnd[TOP_B-1:FRAC_SHIFT];
        end
    end

    assign o_linear      = r_lin;
    assign o_status.busy = (r_state != L_IDLE);
    assign o_status.done = r_done;

    `ASSERT_NEVER(a_start_busy, i_clk, i_rst_n, i_start && (r_state != L_IDLE), "lin busy")
    `ASSERT_AT(a_done_idle, i_clk, i_rst_n, r_done |-> (r_state == L_IDLE), "lin done outside idle")
    `ASSERT_AT(a_prod_fit, i_clk, i_rst_n, (r_state == L_RND) |-> ((r_prod >> FULL_W) == '0), "ovf")

endmodule
